/* rtl/bbe_pkg.sv */
package bbe_pkg;

    // Knot table geometry
    localparam int KNOT_DEPTH = 32;
    localparam int KNOT_AW    = $clog2(KNOT_DEPTH);

    // Degree and counters over triangle rows and positions
    localparam int MAX_DEGREE = 3;
    localparam int DEG_W      = 2;
    localparam int CNT_W      = $clog2(MAX_DEGREE + 1);

    // Fixed point formats
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int DEN_W     = VAL_W + 1;
    localparam int QUO_W     = VAL_W + FRAC_BITS;
    localparam int PROD_W    = VAL_W + QUO_W;
    localparam int STAT_W    = 2;

    localparam logic [VAL_W-1:0] ONE_FX        = VAL_W'(1) << FRAC_BITS;
    localparam logic [DEG_W-1:0] DEGREE_RESET  = DEG_W'(3);

    // Opcodes of an input transaction
    localparam logic OPC_KNOT = 1'b0;
    localparam logic OPC_EVAL = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SPAN = 2'd1,
        STATUS_DZ   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_L,
        ST_RD_R,
        ST_CAP_R,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_R,
        ST_MUL_L,
        ST_UPD,
        ST_EMIT,
        ST_EMIT_ERR
    } state_t;

    typedef struct packed {
        logic knot_wr;
        logic load_item;
        logic rd_right;
        logic cap_left;
        logic cap_right;
        logic start_row;
        logic div_start;
        logic q_zero;
        logic q_load;
        logic mul_right;
        logic mul_left;
        logic upd;
        logic inc_r;
        logic inc_j;
        logic clr_r;
        logic out_load;
        logic out_err;
    } ctrl_cmd_t;

    typedef struct packed {
        logic span_bad;
        logic p_zero;
        logic den_zero;
        logic div_done;
        logic r_last;
        logic j_last;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/bbe_ram.sv */
module bbe_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bbe_divider.sv */
module bbe_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bbe_pkg::QUO_W-1:0] dividend,
    input  logic [bbe_pkg::DEN_W-1:0] divisor,
    output logic                      done,
    output logic [bbe_pkg::QUO_W-1:0] quotient
);
    import bbe_pkg::*;

    // Radix-2 restoring division, two quotient bits per cycle
    localparam int DIV_STEPS = (QUO_W + 1) / 2;
    localparam int DVD_W     = 2 * DIV_STEPS;
    localparam int STEP_CW   = $clog2(DIV_STEPS + 1);

    logic [DVD_W-1:0]   dvd_reg;
    logic [DVD_W-1:0]   dvd_next;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   rem_next;
    logic [DEN_W-1:0]   dvs_reg;
    logic [STEP_CW-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DEN_W:0]     rem_a;
    logic [DEN_W:0]     rem_a_sub;
    logic               ge_a;
    logic [DEN_W:0]     rem_b;
    logic [DEN_W:0]     rem_b_sub;
    logic               ge_b;

    always_comb
    begin
        rem_a     = {rem_reg, dvd_reg[DVD_W-1]};
        ge_a      = rem_a >= {1'b0, dvs_reg};
        rem_a_sub = ge_a ? (rem_a - {1'b0, dvs_reg}) : rem_a;
        rem_b     = {rem_a_sub[DEN_W-1:0], dvd_reg[DVD_W-2]};
        ge_b      = rem_b >= {1'b0, dvs_reg};
        rem_b_sub = ge_b ? (rem_b - {1'b0, dvs_reg}) : rem_b;
        rem_next  = rem_b_sub[DEN_W-1:0];
        dvd_next  = {dvd_reg[DVD_W-3:0], ge_a, ge_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == STEP_CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DVD_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= STEP_CW'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - STEP_CW'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[QUO_W-1:0];

endmodule

/* rtl/bbe_datapath.sv */
module bbe_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bbe_pkg::ctrl_cmd_t         cmd,
    output bbe_pkg::dp_status_t        stat,
    input  logic [bbe_pkg::KNOT_AW-1:0] knot_index,
    input  logic [bbe_pkg::VAL_W-1:0]  knot_value,
    input  logic [bbe_pkg::KNOT_AW-1:0] span_index,
    input  logic [bbe_pkg::VAL_W-1:0]  param_u,
    input  logic                       cfg_wr_en,
    input  logic [bbe_pkg::DEG_W-1:0]  cfg_wr_data,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [bbe_pkg::VAL_W-1:0]  basis_value,
    output logic [bbe_pkg::DEG_W-1:0]  basis_offset,
    output logic [bbe_pkg::STAT_W-1:0] status,
    output logic                       last_result
);
    import bbe_pkg::*;

    logic [DEG_W-1:0]   degree_reg;
    logic [KNOT_AW-1:0] span_reg;
    logic [VAL_W-1:0]   u_reg;
    logic [DEG_W-1:0]   p_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [CNT_W-1:0]   r_reg;
    logic [VAL_W-1:0]   left_reg  [1:MAX_DEGREE];
    logic [VAL_W-1:0]   right_reg [1:MAX_DEGREE];
    logic [VAL_W-1:0]   nb_reg    [0:MAX_DEGREE];
    logic [VAL_W-1:0]   saved_reg;
    logic [QUO_W-1:0]   q_reg;
    logic [PROD_W-1:0]  prod_reg;
    status_t            stat_reg;

    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [DEG_W-1:0]   out_offset_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    logic [KNOT_AW-1:0] rd_addr;
    logic [VAL_W-1:0]   rd_data;
    logic [VAL_W-1:0]   left_new;
    logic [VAL_W-1:0]   right_new;
    logic [CNT_W-1:0]   r_plus;
    logic [CNT_W-1:0]   j_minus_r;
    logic [VAL_W-1:0]   right_sel;
    logic [VAL_W-1:0]   left_sel;
    logic [DEN_W-1:0]   den;
    logic [QUO_W-1:0]   dividend;
    logic [QUO_W-1:0]   quotient;
    logic               div_done;
    logic [VAL_W-1:0]   mul_a;
    logic [PROD_W-1:0]  mul_result;
    logic [VAL_W-1:0]   prod_hi;
    logic [VAL_W:0]     nb_sum;
    logic [KNOT_AW:0]   span_plus1;
    logic [KNOT_AW:0]   span_plus_p;

    // Knot store: written from input transactions, read for the triangle
    bbe_ram #(
        .WIDTH (VAL_W),
        .DEPTH (KNOT_DEPTH)
    ) u_bbe_ram (
        .clk   (clk),
        .we    (cmd.knot_wr),
        .waddr (knot_index),
        .wdata (knot_value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bbe_divider u_bbe_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (den),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        rd_addr   = cmd.rd_right ? (span_reg + KNOT_AW'(j_reg))
                                 : (span_reg + KNOT_AW'(1) - KNOT_AW'(j_reg));
        left_new  = (u_reg > rd_data) ? (u_reg - rd_data) : '0;
        right_new = (rd_data > u_reg) ? (rd_data - u_reg) : '0;

        r_plus    = r_reg + CNT_W'(1);
        j_minus_r = j_reg - r_reg;
        right_sel = right_reg[r_plus];
        left_sel  = left_reg[j_minus_r];
        den       = {1'b0, right_sel} + {1'b0, left_sel};
        dividend  = {nb_reg[r_reg], FRAC_BITS'(0)};

        mul_a      = cmd.mul_left ? left_sel : right_sel;
        mul_result = PROD_W'(mul_a) * PROD_W'(q_reg);
        prod_hi    = prod_reg[FRAC_BITS +: VAL_W];
        nb_sum     = {1'b0, saved_reg} + {1'b0, prod_hi};

        span_plus1  = {1'b0, span_reg} + (KNOT_AW+1)'(1);
        span_plus_p = {1'b0, span_reg} + (KNOT_AW+1)'(p_reg);

        stat.span_bad  = (span_plus1 < (KNOT_AW+1)'(p_reg))
                      || (span_plus_p >= (KNOT_AW+1)'(KNOT_DEPTH));
        stat.p_zero    = p_reg == '0;
        stat.den_zero  = den == '0;
        stat.div_done  = div_done;
        stat.r_last    = r_plus == j_reg;
        stat.j_last    = j_reg == CNT_W'(p_reg);
        stat.emit_last = r_reg == CNT_W'(p_reg);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg    <= DEGREE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                degree_reg <= cfg_wr_data;
            end
            if (cmd.out_load || cmd.out_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            span_reg  <= span_index;
            u_reg     <= param_u;
            p_reg     <= degree_reg;
            nb_reg[0] <= ONE_FX;
            for (int k = 1; k <= MAX_DEGREE; k++)
            begin
                nb_reg[k] <= '0;
            end
            stat_reg  <= STATUS_OK;
            j_reg     <= CNT_W'(1);
            r_reg     <= '0;
        end
        if (cmd.start_row)
        begin
            saved_reg <= '0;
            r_reg     <= '0;
        end
        if (cmd.cap_left)
        begin
            left_reg[j_reg] <= left_new;
        end
        if (cmd.cap_right)
        begin
            right_reg[j_reg] <= right_new;
        end
        if (cmd.q_zero)
        begin
            q_reg    <= '0;
            stat_reg <= STATUS_DZ;
        end
        if (cmd.q_load)
        begin
            q_reg <= quotient;
        end
        if (cmd.mul_right)
        begin
            prod_reg <= mul_result;
        end
        if (cmd.mul_left)
        begin
            nb_reg[r_reg] <= nb_sum[VAL_W-1:0];
            prod_reg      <= mul_result;
        end
        if (cmd.upd)
        begin
            saved_reg <= prod_hi;
            if (stat.r_last)
            begin
                nb_reg[j_reg] <= prod_hi;
            end
        end
        if (cmd.inc_r)
        begin
            r_reg <= r_plus;
        end
        if (cmd.clr_r)
        begin
            r_reg <= '0;
        end
        if (cmd.inc_j)
        begin
            j_reg <= j_reg + CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= nb_reg[r_reg];
            out_offset_reg <= DEG_W'(r_reg);
            out_status_reg <= stat_reg;
            out_last_reg   <= stat.emit_last;
        end
        if (cmd.out_err)
        begin
            out_value_reg  <= '0;
            out_offset_reg <= '0;
            out_status_reg <= STATUS_SPAN;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign basis_value  = out_value_reg;
    assign basis_offset = out_offset_reg;
    assign status       = out_status_reg;
    assign last_result  = out_last_reg;

endmodule

/* rtl/bbe_ctrl.sv */
module bbe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                opcode,
    input  bbe_pkg::dp_status_t stat,
    output logic                in_stall,
    output bbe_pkg::ctrl_cmd_t  cmd
);
    import bbe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = state_reg != ST_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OPC_KNOT)
                    begin
                        cmd.knot_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (stat.span_bad)
                begin
                    state_next = ST_EMIT_ERR;
                end
                else if (stat.p_zero)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_RD_L;
                end
            end
            ST_RD_L:
            begin
                // Fetch the left knot of this row; reset row accumulators
                cmd.start_row = 1'b1;
                state_next    = ST_RD_R;
            end
            ST_RD_R:
            begin
                cmd.rd_right = 1'b1;
                cmd.cap_left = 1'b1;
                state_next   = ST_CAP_R;
            end
            ST_CAP_R:
            begin
                cmd.cap_right = 1'b1;
                state_next    = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                if (stat.den_zero)
                begin
                    cmd.q_zero = 1'b1;
                    state_next = ST_MUL_R;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.q_load = 1'b1;
                    state_next = ST_MUL_R;
                end
            end
            ST_MUL_R:
            begin
                cmd.mul_right = 1'b1;
                state_next    = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                cmd.mul_left = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd = 1'b1;
                if (!stat.r_last)
                begin
                    cmd.inc_r  = 1'b1;
                    state_next = ST_DIV_START;
                end
                else if (!stat.j_last)
                begin
                    cmd.inc_j  = 1'b1;
                    state_next = ST_RD_L;
                end
                else
                begin
                    cmd.clr_r  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.inc_r = 1'b1;
                    end
                end
            end
            ST_EMIT_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_err = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bspline_basis_evaluator_unit.sv */
// B-spline basis evaluator (Cox-de Boor triangle), 16 fraction bit fixed point.
//
// Input channel (in_valid / in_stall): one transaction is either a knot write
// (opcode 0: knot_value goes to table entry knot_index, no result) or an
// evaluation (opcode 1: span_index and param_u). A knot write completes in the
// accepting cycle. An evaluation produces degree+1 result transactions on the
// output channel (out_valid / out_stall), positions 0..degree in order, the
// final one marked by last_result; a span that leaves the knot table gives a
// single result with status 1, and a zero denominator marks every result of
// that evaluation with status 2.
//
// Per evaluation: knot reads, one quotient per triangle cell (forced to zero
// for a zero denominator, else from a shared two-bits-per-cycle divider) and
// two passes through one shared multiplier. in_stall is high from acceptance
// of an evaluation until its last result is loaded into the output register.
//
// The output register holds a result while out_stall is high; the block waits
// for it to drain before loading the next one. Reset returns to idle, empties
// the output register and sets degree to 3; the knot table keeps no reset.
// cfg_wr_en writes cfg_wr_data into degree; write it only while idle.
module bspline_basis_evaluator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [bbe_pkg::KNOT_AW-1:0] knot_index,
    input  logic [bbe_pkg::VAL_W-1:0]   knot_value,
    input  logic [bbe_pkg::KNOT_AW-1:0] span_index,
    input  logic [bbe_pkg::VAL_W-1:0]   param_u,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bbe_pkg::VAL_W-1:0]   basis_value,
    output logic [bbe_pkg::DEG_W-1:0]   basis_offset,
    output logic [bbe_pkg::STAT_W-1:0]  status,
    output logic                        last_result,
    input  logic                        cfg_wr_en,
    input  logic [bbe_pkg::DEG_W-1:0]   cfg_wr_data
);
    import bbe_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    // Sequencer: walks the triangle rows and cells, then drains results
    bbe_ctrl u_bbe_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .stat     (dp_stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Knot store, differences, divider, multiplier and output register
    bbe_datapath u_bbe_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (dp_stat),
        .knot_index   (knot_index),
        .knot_value   (knot_value),
        .span_index   (span_index),
        .param_u      (param_u),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .basis_value  (basis_value),
        .basis_offset (basis_offset),
        .status       (status),
        .last_result  (last_result)
    );

endmodule

/* rtl/bbe_checker.sv */
module bbe_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        opcode,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [bbe_pkg::VAL_W-1:0]   basis_value,
    input logic [bbe_pkg::DEG_W-1:0]   basis_offset,
    input logic [bbe_pkg::STAT_W-1:0]  status,
    input logic                        last_result
);
    import bbe_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(basis_value)
            && $stable(basis_offset) && $stable(status) && $stable(last_result))
        else $error("stalled result changed");

    a_span_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_SPAN |->
            last_result && basis_value == '0 && basis_offset == '0)
        else $error("span error result malformed");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> basis_value <= ONE_FX)
        else $error("basis value above 1.0");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OPC_EVAL |=> in_stall)
        else $error("evaluation accepted without going busy");

    // The next value of an evaluation follows a drained one without a gap
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_result |=> out_valid)
        else $error("result stream broke off before the final value");

endmodule

bind bspline_basis_evaluator_unit bbe_checker u_bbe_checker (.*);

/* sim/bspline_basis_evaluator_unit_tb.sv */
`timescale 1ns / 1ps

module bspline_basis_evaluator_unit_tb;
    import bbe_pkg::*;

    // One input transaction: knot write or evaluation
    typedef struct packed {
        logic                opcode;
        logic [KNOT_AW-1:0]  knot_index;
        logic [VAL_W-1:0]    knot_value;
        logic [KNOT_AW-1:0]  span_index;
        logic [VAL_W-1:0]    param_u;
    } basis_req_t;

    // One result transaction: a single basis value
    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [DEG_W-1:0]    offset;
        status_t             stat;
        logic                last_flag;
    } basis_res_t;

    // Mirror of the knot table and degree register; expands every accepted
    // evaluation into its basis values and matches them against the output.
    class basis_scoreboard;
        logic [VAL_W-1:0] knots [KNOT_DEPTH];
        bit               written [KNOT_DEPTH];
        logic [DEG_W-1:0] degree;
        basis_res_t       pending_basis [$];
        int               errors;
        int               knot_writes;
        int               evaluations;
        int               results_seen;

        function new();
            degree       = DEGREE_RESET;
            errors       = 0;
            knot_writes  = 0;
            evaluations  = 0;
            results_seen = 0;
        endfunction

        // Difference that floors at zero (u outside its span)
        function longint unsigned clip_diff(longint unsigned a, longint unsigned b);
            return (a > b) ? (a - b) : 64'd0;
        endfunction

        // Queue one expected result behind those already waiting
        function void queue_basis(basis_res_t res);
            pending_basis.insert(pending_basis.size(), res);
        endfunction

        function void note_item(basis_req_t item);
            longint unsigned left  [MAX_DEGREE+1];
            longint unsigned right [MAX_DEGREE+1];
            longint unsigned nb    [MAX_DEGREE+1];
            longint unsigned u;
            longint unsigned den;
            longint unsigned q;
            longint unsigned saved;
            int              p;
            int              span;
            status_t         st;
            basis_res_t      res;

            if (item.opcode == OPC_KNOT) begin
                knots[item.knot_index]   = item.knot_value;
                written[item.knot_index] = 1'b1;
                knot_writes++;
                return;
            end
            evaluations++;
            p = int'(degree);
            if (p > MAX_DEGREE)
                p = MAX_DEGREE;
            span = int'(item.span_index);

            if (span + 1 < p || span + p >= KNOT_DEPTH) begin
                res.value     = '0;
                res.offset    = '0;
                res.stat      = STATUS_SPAN;
                res.last_flag = 1'b1;
                queue_basis(res);
                return;
            end

            u  = item.param_u;
            st = STATUS_OK;
            for (int k = 0; k <= MAX_DEGREE; k++)
            begin
                left[k]  = 0;
                right[k] = 0;
                nb[k]    = 0;
            end
            nb[0] = ONE_FX;

            for (int j = 1; j <= p; j++)
            begin
                saved    = 0;
                left[j]  = clip_diff(u, knots[span + 1 - j]);
                right[j] = clip_diff(knots[span + j], u);
                for (int r = 0; r < j; r++)
                begin
                    den = right[r+1] + left[j-r];
                    q   = 0;
                    if (den == 0)
                        st = STATUS_DZ;
                    else
                        q = (nb[r] << FRAC_BITS) / den;
                    nb[r] = saved + ((right[r+1] * q) >> FRAC_BITS);
                    saved = (left[j-r] * q) >> FRAC_BITS;
                end
                nb[j] = saved;
            end

            for (int r = 0; r <= p; r++)
            begin
                res.value     = VAL_W'(nb[r]);
                res.offset    = DEG_W'(r);
                res.stat      = st;
                res.last_flag = (r == p);
                queue_basis(res);
            end
        endfunction

        task report(string what);
            errors++;
            $display("ERROR @%0t: %s", $time, what);
        endtask

        task check_basis(basis_res_t got);
            basis_res_t want;
            results_seen++;
            if (pending_basis.size() == 0) begin
                report($sformatf("unexpected result value=%0d offset=%0d status=%0d last=%0d",
                                 got.value, got.offset, got.stat, got.last_flag));
                return;
            end
            want = pending_basis.pop_front();
            if (got.value !== want.value || got.offset !== want.offset ||
                got.stat !== want.stat || got.last_flag !== want.last_flag)
                report($sformatf("value=%0d offset=%0d status=%0d last=%0d, want %0d/%0d/%0d/%0d",
                                 got.value, got.offset, got.stat, got.last_flag,
                                 want.value, want.offset, want.stat, want.last_flag));
        endtask
    endclass

    // Clock and reset
    logic clk;
    logic rst_n = 1'b0;

    // Input channel
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic               opcode     = OPC_KNOT;
    logic [KNOT_AW-1:0] knot_index = '0;
    logic [VAL_W-1:0]   knot_value = '0;
    logic [KNOT_AW-1:0] span_index = '0;
    logic [VAL_W-1:0]   param_u    = '0;

    // Output channel
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [VAL_W-1:0]   basis_value;
    logic [DEG_W-1:0]   basis_offset;
    logic [STAT_W-1:0]  status;
    logic               last_result;

    // Degree register port
    logic               cfg_wr_en   = 1'b0;
    logic [DEG_W-1:0]   cfg_wr_data = '0;

    basis_scoreboard sb = new();

    // Idle mix of the current phase, in percent per cycle
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int phase_degree [8] = '{2, 3, 1, 3, 2, 0, 1, 3};

    bspline_basis_evaluator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .knot_index   (knot_index),
        .knot_value   (knot_value),
        .span_index   (span_index),
        .param_u      (param_u),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .basis_value  (basis_value),
        .basis_offset (basis_offset),
        .status       (status),
        .last_result  (last_result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("bspline_basis_evaluator_unit regression: fail");
        $finish;
    end

    // Output side: check every result transaction that completes at this
    // edge, then roll the stall for the next cycle. Values read here are the
    // ones the DUT presented at the edge.
    always @(posedge clk)
    begin
        basis_res_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.value     = basis_value;
            got.offset    = basis_offset;
            got.stat      = status_t'(status);
            got.last_flag = last_result;
            sb.check_basis(got);
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Knot and parameter values, biased toward 0.0 and 1.0
    function automatic logic [VAL_W-1:0] rand_fx();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return ONE_FX;
        return VAL_W'($urandom_range(0, int'(ONE_FX)));
    endfunction

    // Present one transaction and hold it until accepted. Valid stays high
    // when the next transaction follows without a gap.
    task automatic send_item(basis_req_t item);
        int gaps;
        gaps = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gaps++;
        if (gaps > 0) begin
            in_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= item.opcode;
        knot_index <= item.knot_index;
        knot_value <= item.knot_value;
        span_index <= item.span_index;
        param_u    <= item.param_u;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(item);
        items_sent++;
    endtask

    // Unused fields of a transaction carry random values
    task automatic write_knot(int idx, logic [VAL_W-1:0] val);
        basis_req_t item;
        item.opcode     = OPC_KNOT;
        item.knot_index = KNOT_AW'(idx);
        item.knot_value = val;
        item.span_index = KNOT_AW'($urandom_range(0, KNOT_DEPTH - 1));
        item.param_u    = rand_fx();
        send_item(item);
    endtask

    task automatic evaluate(int span, logic [VAL_W-1:0] u);
        basis_req_t item;
        item.opcode     = OPC_EVAL;
        item.knot_index = KNOT_AW'($urandom_range(0, KNOT_DEPTH - 1));
        item.knot_value = rand_fx();
        item.span_index = KNOT_AW'(span);
        item.param_u    = u;
        send_item(item);
    endtask

    // Drop valid and hold off until every expected result has drained
    task automatic drain(int settle);
        in_valid <= 1'b0;
        while (sb.pending_basis.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Degree is written only with the block idle
    task automatic set_degree(int d);
        drain(20);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= DEG_W'(d);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.degree    = DEG_W'(d);
    endtask

    // Knots read by span i at the current degree: i+1-p .. i+p
    function automatic bit span_ready(int span);
        for (int k = span + 1 - int'(sb.degree); k <= span + int'(sb.degree); k++)
            if (!sb.written[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Fill any knot the span reads that was never written
    task automatic ensure_span(int span);
        for (int k = span + 1 - int'(sb.degree); k <= span + int'(sb.degree); k++)
            if (!sb.written[k])
                write_knot(k, rand_fx());
    endtask

    // Write a nondecreasing knot run around the span, repeats included
    task automatic fill_ordered(int span);
        int v;
        int p;
        p = int'(sb.degree);
        v = $urandom_range(0, 30000);
        for (int k = span + 1 - p; k <= span + p; k++)
        begin
            if ($urandom_range(0, 4) != 0)
                v += $urandom_range(1, 16000);
            if (v > int'(ONE_FX))
                v = int'(ONE_FX);
            write_knot(k, VAL_W'(v));
        end
    endtask

    task automatic set_idle_mix(int mix);
        case (mix)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 71; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 71; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
        endcase
    endtask

    // Hand-picked cases on a clamped uniform cubic knot vector
    task automatic directed_checks();
        for (int k = 0; k <= 3; k++)
            write_knot(k, '0);
        write_knot(4, 17'd16384);
        write_knot(5, 17'd32768);
        write_knot(6, 17'd49152);
        for (int k = 7; k <= 10; k++)
            write_knot(k, ONE_FX);
        write_knot(KNOT_DEPTH - 1, ONE_FX);

        // Degree 3 straight out of reset
        evaluate(3, '0);            // u at the very start of the curve
        evaluate(4, 17'd20000);     // interior span
        evaluate(6, ONE_FX);        // u at 1.0
        evaluate(2, '0);            // repeated knots: zero denominator
        evaluate(4, 17'd60000);     // u past its span, differences clip
        evaluate(0, 17'd12345);     // span too low for the degree
        evaluate(KNOT_DEPTH - 1, ONE_FX); // span runs off the table end

        set_degree(0);
        evaluate(17, 17'd30000);    // degree zero: single 1.0

        set_degree(1);
        evaluate(KNOT_DEPTH - 1, '0);
        evaluate(0, '0);            // U0 = U1 = u: zero denominator
    endtask

    // Mostly well-formed spans with u inside, plus stray knot writes,
    // unordered knots and spans that leave the table
    task automatic run_random(int n);
        int stop;
        int kind;
        int p;
        int span;
        int reps;
        stop = items_sent + n;
        while (items_sent < stop) begin
            p    = int'(sb.degree);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                if (p == 0)
                    span = $urandom_range(0, KNOT_DEPTH - 1);
                else
                    span = $urandom_range(p - 1, KNOT_DEPTH - 1 - p);
                if (!span_ready(span) || $urandom_range(0, 1) == 1)
                    fill_ordered(span);
                reps = $urandom_range(1, 3);
                repeat (reps)
                begin
                    if (p == 0 || $urandom_range(0, 4) == 0)
                        evaluate(span, rand_fx());
                    else
                        evaluate(span, VAL_W'($urandom_range(int'(sb.knots[span + 1]),
                                                             int'(sb.knots[span]))));
                end
            end else if (kind < 85) begin
                write_knot($urandom_range(0, KNOT_DEPTH - 1), rand_fx());
            end else if (kind < 93 || p == 0) begin
                span = $urandom_range(0, KNOT_DEPTH - 1);
                if (!(span + 1 < p || span + p >= KNOT_DEPTH))
                    ensure_span(span);
                evaluate(span, rand_fx());
            end else begin
                if (p >= 2 && $urandom_range(0, 1) == 1)
                    span = $urandom_range(0, p - 2);
                else
                    span = $urandom_range(KNOT_DEPTH - p, KNOT_DEPTH - 1);
                evaluate(span, rand_fx());
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        // Each phase: new degree (written with the block drained), new idle mix
        for (int ph = 0; ph < 8; ph++)
        begin
            set_degree(phase_degree[ph]);
            set_idle_mix(ph % 4);
            run_random(15);
        end

        set_idle_mix(0);
        drain(200);

        $display("Covered %0d knot writes and %0d evaluations at degrees 0 to 3,",
                 sb.knot_writes, sb.evaluations);
        $display("%0d basis values checked under four sender/receiver idle mixes.",
                 sb.results_seen);
        if (sb.errors == 0)
            $display("bspline_basis_evaluator_unit regression: pass");
        else
            $display("bspline_basis_evaluator_unit regression: fail");
        $finish;
    end

endmodule
